@@ sv/qet_pkg.sv @@
package qet_pkg;

  // scan modes
  localparam logic [3:0] MODE_BETWEEN     = 4'd0;
  localparam logic [3:0] MODE_BARE        = 4'd1;
  localparam logic [3:0] MODE_QUOTED      = 4'd2;
  localparam logic [3:0] MODE_ESCAPE      = 4'd3;
  localparam logic [3:0] MODE_HEX_FIRST   = 4'd4;
  localparam logic [3:0] MODE_HEX_SECOND  = 4'd5;
  localparam logic [3:0] MODE_AFTER_QUOTE = 4'd6;
  localparam logic [3:0] MODE_COMMENT     = 4'd7;
  localparam logic [3:0] MODE_FAILED      = 4'd8;

  // input opcodes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_OK    = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // error codes
  localparam logic [2:0] ERR_TRAILING_ESCAPE  = 3'd0;
  localparam logic [2:0] ERR_INCOMPLETE_HEX   = 3'd1;
  localparam logic [2:0] ERR_BAD_HEX          = 3'd2;
  localparam logic [2:0] ERR_BAD_ESCAPE       = 3'd3;
  localparam logic [2:0] ERR_UNTERMINATED     = 3'd4;
  localparam logic [2:0] ERR_JUNK_AFTER_QUOTE = 3'd5;
  localparam logic [2:0] ERR_QUOTE_IN_BARE    = 3'd6;

  // characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;

  // output queue
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tok_byte;
    logic [2:0] err_code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [3:0] mode_next;
    logic [7:0] held_next;
    logic [1:0] cnt;        // results produced: 0..2
    res_t       r0;
    res_t       r1;
  } dec_t;

  function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] b,
                                  input logic [2:0] err);
    res_t r;
    r.kind     = kind;
    r.tok_byte = b;
    r.err_code = err;
    r.last     = 1'b0;
    return r;
  endfunction

  // {valid, value}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] n;
    n = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) n = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) n = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) n = {1'b1, 4'(c - 8'h37)};
    return n;
  endfunction

endpackage

@@ sv/qet_decode.sv @@
module qet_decode (
  input  logic [3:0]    mode,
  input  logic [7:0]    held,
  input  logic          opcode,
  input  logic [7:0]    ch,
  output qet_pkg::dec_t dec
);
  import qet_pkg::*;

  logic       is_sep;
  logic [4:0] hi_n;
  logic [4:0] lo_n;

  assign is_sep = (ch == CH_SPACE) || (ch == CH_TAB);
  assign hi_n   = nibble_of(held);
  assign lo_n   = nibble_of(ch);

  always_comb begin
    dec.mode_next = mode;
    dec.held_next = held;
    dec.cnt       = 2'd0;
    dec.r0        = '0;
    dec.r1        = '0;

    if (opcode == OP_EOL) begin
      dec.mode_next = MODE_BETWEEN;
      dec.held_next = 8'd0;
      unique case (mode)
        MODE_BARE: begin
          dec.r0  = mk_res(KIND_END, 8'd0, 3'd0);
          dec.r1  = mk_res(KIND_OK, 8'd0, 3'd0);
          dec.cnt = 2'd2;
        end
        MODE_QUOTED: begin
          dec.r0  = mk_res(KIND_ERROR, 8'd0, ERR_UNTERMINATED);
          dec.cnt = 2'd1;
        end
        MODE_ESCAPE: begin
          dec.r0  = mk_res(KIND_ERROR, 8'd0, ERR_TRAILING_ESCAPE);
          dec.cnt = 2'd1;
        end
        MODE_HEX_FIRST, MODE_HEX_SECOND: begin
          dec.r0  = mk_res(KIND_ERROR, 8'd0, ERR_INCOMPLETE_HEX);
          dec.cnt = 2'd1;
        end
        MODE_FAILED: begin
        end
        default: begin
          dec.r0  = mk_res(KIND_OK, 8'd0, 3'd0);
          dec.cnt = 2'd1;
        end
      endcase
    end else begin
      unique case (mode)
        MODE_BARE: begin
          dec.cnt = 2'd1;
          if (is_sep) begin
            dec.r0        = mk_res(KIND_END, 8'd0, 3'd0);
            dec.mode_next = MODE_BETWEEN;
          end else if (ch == CH_HASH) begin
            dec.r0        = mk_res(KIND_END, 8'd0, 3'd0);
            dec.mode_next = MODE_COMMENT;
          end else if (ch == CH_QUOTE) begin
            dec.r0        = mk_res(KIND_ERROR, 8'd0, ERR_QUOTE_IN_BARE);
            dec.mode_next = MODE_FAILED;
          end else begin
            dec.r0 = mk_res(KIND_BYTE, ch, 3'd0);
          end
        end
        MODE_QUOTED: begin
          if (ch == CH_QUOTE) begin
            dec.r0        = mk_res(KIND_END, 8'd0, 3'd0);
            dec.cnt       = 2'd1;
            dec.mode_next = MODE_AFTER_QUOTE;
          end else if (ch == CH_BSLASH) begin
            dec.mode_next = MODE_ESCAPE;
          end else begin
            dec.r0  = mk_res(KIND_BYTE, ch, 3'd0);
            dec.cnt = 2'd1;
          end
        end
        MODE_ESCAPE: begin
          dec.mode_next = MODE_QUOTED;
          dec.cnt       = 2'd1;
          if (ch == CH_BSLASH || ch == CH_QUOTE) begin
            dec.r0 = mk_res(KIND_BYTE, ch, 3'd0);
          end else if (ch == CH_N) begin
            dec.r0 = mk_res(KIND_BYTE, CH_LF, 3'd0);
          end else if (ch == CH_R) begin
            dec.r0 = mk_res(KIND_BYTE, CH_CR, 3'd0);
          end else if (ch == CH_T) begin
            dec.r0 = mk_res(KIND_BYTE, CH_TAB, 3'd0);
          end else if (ch == CH_X) begin
            dec.cnt       = 2'd0;
            dec.mode_next = MODE_HEX_FIRST;
          end else begin
            dec.r0        = mk_res(KIND_ERROR, 8'd0, ERR_BAD_ESCAPE);
            dec.mode_next = MODE_FAILED;
          end
        end
        MODE_HEX_FIRST: begin
          dec.held_next = ch;
          dec.mode_next = MODE_HEX_SECOND;
        end
        MODE_HEX_SECOND: begin
          dec.held_next = 8'd0;
          dec.cnt       = 2'd1;
          if (!hi_n[4] || !lo_n[4]) begin
            dec.r0        = mk_res(KIND_ERROR, 8'd0, ERR_BAD_HEX);
            dec.mode_next = MODE_FAILED;
          end else begin
            dec.r0        = mk_res(KIND_BYTE, {hi_n[3:0], lo_n[3:0]}, 3'd0);
            dec.mode_next = MODE_QUOTED;
          end
        end
        MODE_AFTER_QUOTE: begin
          if (is_sep) begin
            dec.mode_next = MODE_BETWEEN;
          end else if (ch == CH_HASH) begin
            dec.mode_next = MODE_COMMENT;
          end else begin
            dec.r0        = mk_res(KIND_ERROR, 8'd0, ERR_JUNK_AFTER_QUOTE);
            dec.cnt       = 2'd1;
            dec.mode_next = MODE_FAILED;
          end
        end
        MODE_COMMENT, MODE_FAILED: begin
        end
        default: begin
          // between tokens, and any unused code
          if (is_sep) begin
            dec.mode_next = MODE_BETWEEN;
          end else if (ch == CH_HASH) begin
            dec.mode_next = MODE_COMMENT;
          end else if (ch == CH_QUOTE) begin
            dec.mode_next = MODE_QUOTED;
          end else begin
            dec.r0        = mk_res(KIND_BYTE, ch, 3'd0);
            dec.cnt       = 2'd1;
            dec.mode_next = MODE_BARE;
          end
        end
      endcase
    end

    if (dec.cnt == 2'd1) dec.r0.last = 1'b1;
    if (dec.cnt == 2'd2) dec.r1.last = 1'b1;
  end

endmodule

@@ sv/quoted_escape_tokenizer_top.sv @@
// Line tokenizer: takes one character or end-of-line transfer per cycle while the output queue
// has room, and emits token bytes, token ends and one line ok/error result per line. Each
// transfer passes the input register, then is decoded into a four-entry output queue.
// The output port moves one result per cycle while the receiver is ready; the only item
// that yields two results is an end of line that closes a bare token (token end plus line
// ok). The decoder advances only when the queue has room for two results.
module quoted_escape_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic [0:0]  s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] token_byte, [10:8] error_code, [15:11] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);
  import qet_pkg::*;

  // input register
  logic       in_valid;
  logic       in_op;
  logic [7:0] in_char;

  // scan state
  logic [3:0] mode;
  logic [7:0] held;

  // output queue, entry 0 is the head
  res_t       q [QDEPTH];
  res_t       q_next [QDEPTH];
  logic [2:0] cnt;
  logic [2:0] cnt_next;
  logic [2:0] cnt_p;

  logic pop;
  logic adv;
  dec_t dec;

  qet_decode u_decode (
    .mode   (mode),
    .held   (held),
    .opcode (in_op),
    .ch     (in_char),
    .dec    (dec)
  );

  assign pop           = (cnt != 3'd0) && m_axis_tready;
  assign cnt_p         = cnt - {2'b0, pop};
  assign adv           = in_valid && (cnt_p <= 3'd2);
  assign s_axis_tready = !in_valid || adv;

  always_comb begin
    for (int i = 0; i < QDEPTH - 1; i++) begin
      q_next[i] = pop ? q[i + 1] : q[i];
    end
    q_next[QDEPTH-1] = q[QDEPTH-1];
    for (int i = 0; i < QDEPTH; i++) begin
      if (adv && dec.cnt != 2'd0 && cnt_p == 3'(i)) q_next[i] = dec.r0;
      if (adv && dec.cnt == 2'd2 && cnt_p + 3'd1 == 3'(i)) q_next[i] = dec.r1;
    end
    cnt_next = adv ? cnt_p + {1'b0, dec.cnt} : cnt_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      mode     <= MODE_BETWEEN;
      held     <= 8'd0;
      cnt      <= 3'd0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (adv) begin
        mode <= dec.mode_next;
        held <= dec.held_next;
      end
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op   <= s_axis_tuser[0];
      in_char <= s_axis_tdata;
    end
    q <= q_next;
  end

  assign m_axis_tvalid = (cnt != 3'd0);
  assign m_axis_tdata  = {5'b0, q[0].err_code, q[0].tok_byte};
  assign m_axis_tuser  = q[0].kind;
  assign m_axis_tlast  = q[0].last;

endmodule

@@ sv/qet_checker.sv @@
module qet_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import qet_pkg::*;

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // input register is empty after reset, so the input side is ready
  a_reset_ready: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready right after reset");

  // a line result is always the final result of its transfer
  a_line_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_OK || m_axis_tuser == KIND_ERROR)
      |-> m_axis_tlast)
    else $error("line result without tlast");

  // error code only carried by error results
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_ERROR |-> m_axis_tdata[10:8] == 3'd0)
    else $error("error code on non-error result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready
      |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
          && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind quoted_escape_tokenizer_top qet_checker u_qet_checker (.*);

@@ dv/quoted_escape_tokenizer_top_test.sv @@
`timescale 1ns / 100ps

module quoted_escape_tokenizer_top_test;
  import qet_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct packed {
    logic       pause;    // sender waits here until all results are in
    logic       op;
    logic [7:0] ch;
  } line_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_byte
  logic [0:0]  s_axis_tuser = 1'b0;    // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] token_byte, [10:8] error_code, [15:11] zero
  logic [1:0]  m_axis_tuser;           // [1:0] kind
  logic        m_axis_tlast;

  quoted_escape_tokenizer_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  line_item_t pending_chars[$];
  res_t       expected_results[$];
  res_t       step_out[$];
  int         total_items = 0;
  int         accepted_count = 0;
  int         mismatches = 0;
  int         cycles = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  line_item_t next_item;
  res_t       want;

  // tokenizer state mirror
  logic [3:0] scan_state = MODE_BETWEEN;
  logic [7:0] held_digit = 8'h00;

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void put_result(logic [1:0] kind, logic [7:0] b, logic [2:0] err);
    res_t r;
    r.kind     = kind;
    r.tok_byte = b;
    r.err_code = err;
    r.last     = 1'b0;
    step_out = {step_out, r};
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    put_result(KIND_BYTE, b, '0);
  endfunction

  function automatic void mark(logic [1:0] kind);
    put_result(kind, '0, '0);
  endfunction

  function automatic void flag_error(logic [2:0] err);
    put_result(KIND_ERROR, '0, err);
    scan_state = MODE_FAILED;
  endfunction

  // advance the mirror by one accepted transfer and queue what it yields
  function automatic void tokenize_step(logic op, logic [7:0] c);
    int   hi;
    int   lo;
    res_t r;
    step_out.delete();
    if (op == OP_EOL) begin
      case (scan_state)
        MODE_BARE: begin
          mark(KIND_END);
          mark(KIND_OK);
        end
        MODE_QUOTED:                   flag_error(ERR_UNTERMINATED);
        MODE_ESCAPE:                   flag_error(ERR_TRAILING_ESCAPE);
        MODE_HEX_FIRST, MODE_HEX_SECOND: flag_error(ERR_INCOMPLETE_HEX);
        MODE_FAILED: ;
        default:                       mark(KIND_OK);
      endcase
      scan_state = MODE_BETWEEN;
      held_digit = 8'h00;
    end else begin
      case (scan_state)
        MODE_BARE: begin
          if (is_blank(c)) begin
            mark(KIND_END);
            scan_state = MODE_BETWEEN;
          end else if (c == CH_HASH) begin
            mark(KIND_END);
            scan_state = MODE_COMMENT;
          end else if (c == CH_QUOTE) begin
            flag_error(ERR_QUOTE_IN_BARE);
          end else begin
            emit_byte(c);
          end
        end
        MODE_QUOTED: begin
          if (c == CH_QUOTE) begin
            mark(KIND_END);
            scan_state = MODE_AFTER_QUOTE;
          end else if (c == CH_BSLASH) begin
            scan_state = MODE_ESCAPE;
          end else begin
            emit_byte(c);
          end
        end
        MODE_ESCAPE: begin
          scan_state = MODE_QUOTED;
          if (c == CH_BSLASH || c == CH_QUOTE) emit_byte(c);
          else if (c == CH_N) emit_byte(CH_LF);
          else if (c == CH_R) emit_byte(CH_CR);
          else if (c == CH_T) emit_byte(CH_TAB);
          else if (c == CH_X) scan_state = MODE_HEX_FIRST;
          else flag_error(ERR_BAD_ESCAPE);
        end
        MODE_HEX_FIRST: begin
          held_digit = c;
          scan_state = MODE_HEX_SECOND;
        end
        MODE_HEX_SECOND: begin
          hi = hex_value(held_digit);
          lo = hex_value(c);
          held_digit = 8'h00;
          if (hi < 0 || lo < 0) begin
            flag_error(ERR_BAD_HEX);
          end else begin
            emit_byte(8'(hi * 16 + lo));
            scan_state = MODE_QUOTED;
          end
        end
        MODE_AFTER_QUOTE: begin
          if (is_blank(c)) scan_state = MODE_BETWEEN;
          else if (c == CH_HASH) scan_state = MODE_COMMENT;
          else flag_error(ERR_JUNK_AFTER_QUOTE);
        end
        MODE_COMMENT, MODE_FAILED: ;
        default: begin
          if (is_blank(c)) begin
            scan_state = MODE_BETWEEN;
          end else if (c == CH_HASH) begin
            scan_state = MODE_COMMENT;
          end else if (c == CH_QUOTE) begin
            scan_state = MODE_QUOTED;
          end else begin
            emit_byte(c);
            scan_state = MODE_BARE;
          end
        end
      endcase
    end
    foreach (step_out[i]) begin
      r = step_out[i];
      r.last = (i == step_out.size() - 1);
      expected_results = {expected_results, r};
    end
  endfunction

  // 0: light sender gaps, heavy receiver stalls; 1: the reverse; 2: full rate
  function automatic int run_phase();
    if (accepted_count < total_items / 3) return 0;
    if (accepted_count < 2 * total_items / 3) return 1;
    return 2;
  endfunction

  function automatic logic [7:0] random_byte_avoiding(logic [7:0] a, logic [7:0] b,
                                                      logic [7:0] c, logic [7:0] d);
    logic [7:0] v;
    do v = 8'($urandom_range(255));
    while (v == a || v == b || v == c || v == d);
    return v;
  endfunction

  function automatic logic [7:0] special_char();
    case ($urandom_range(7))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_QUOTE;
      3: return CH_HASH;
      4: return CH_BSLASH;
      5: return CH_X;
      6: return CH_N;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_item(logic op, logic [7:0] ch);
    line_item_t it;
    it.pause = 1'b0;
    it.op    = op;
    it.ch    = ch;
    pending_chars = {pending_chars, it};
    total_items++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_item(OP_CHAR, s[i]);
  endtask

  task automatic queue_eol();
    queue_item(OP_EOL, 8'($urandom_range(255)));
  endtask

  task automatic queue_pause();
    line_item_t it;
    it = '0;
    it.pause = 1'b1;
    pending_chars = {pending_chars, it};
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        tokenize_step(s_axis_tuser[0], s_axis_tdata);
        accepted_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_chars.size() > 0 && pending_chars[0].pause &&
            expected_results.size() == 0)
          void'(pending_chars.pop_front());
        if (pending_chars.size() > 0 && !pending_chars[0].pause &&
            $urandom_range(99) >= (run_phase() == 0 ? 12 : run_phase() == 1 ? 72 : 0)) begin
          next_item = pending_chars.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_item.ch;
          s_axis_tuser  <= next_item.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off so the output queue backs up into the input
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_count >= total_items / 6) begin
      hold_done <= 1'b1;
      hold_left <= 90;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99) >=
                       (run_phase() == 0 ? 72 : run_phase() == 1 ? 12 : 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: kind %0d data %h last %b", $time,
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.kind ||
            m_axis_tdata !== {5'b0, want.err_code, want.tok_byte} ||
            m_axis_tlast !== want.last) begin
          $display("%0t: expected kind %0d data %h last %b, got kind %0d data %h last %b",
                   $time, want.kind, {5'b0, want.err_code, want.tok_byte}, want.last,
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d transfers taken, %0d results outstanding",
               $time, accepted_count, total_items, expected_results.size());
      $display("FAIL quoted_escape_tokenizer_top");
      $finish;
    end
  end

  initial begin
    int         sel;
    int         ntok;
    int         len;
    int         pos;
    bit         mid_pause;
    string      hex_chars;
    logic [7:0] line_text[$];

    hex_chars = "0123456789abcdefABCDEF";
    mid_pause = 1'b0;

    // byte extremes, hex escape, closing quote into a comment, comment body ignored
    queue_item(OP_CHAR, 8'h00);
    queue_item(OP_CHAR, 8'hFF);
    queue_item(OP_CHAR, CH_TAB);
    queue_text("\"\\xaF\"#z");
    queue_eol();
    // CR is an ordinary bare character; quote in bare token, then a silent end of line
    queue_item(OP_CHAR, CH_CR);
    queue_text("\"");
    queue_eol();
    // empty quoted token followed by junk
    queue_text("\"\"\"");
    queue_eol();
    // end of line with a non-hex held digit still counts as incomplete hex
    queue_text("\"\\xg");
    queue_eol();
    queue_text("\"\\q");
    queue_eol();
    queue_pause();

    while (total_items < RANDOM_ITEMS + 30) begin
      if (!mid_pause && total_items > RANDOM_ITEMS / 2) begin
        queue_pause();
        mid_pause = 1'b1;
      end
      line_text.delete();
      sel = $urandom_range(99);
      if (sel < 8) begin
        len = $urandom_range(12);
        repeat (len) line_text = {line_text, ($urandom_range(1) ? special_char()
                                                                : 8'($urandom_range(255)))};
      end else begin
        ntok = $urandom_range(4);
        for (int t = 0; t < ntok; t++) begin
          repeat ($urandom_range(t == 0 ? 0 : 1, 2))
            line_text = {line_text, ($urandom_range(1) ? CH_SPACE : CH_TAB)};
          if ($urandom_range(1)) begin
            repeat ($urandom_range(1, 6))
              line_text = {line_text,
                           random_byte_avoiding(CH_SPACE, CH_TAB, CH_HASH, CH_QUOTE)};
          end else begin
            line_text = {line_text, CH_QUOTE};
            repeat ($urandom_range(6)) begin
              if ($urandom_range(9) < 6) begin
                line_text = {line_text, random_byte_avoiding(CH_QUOTE, CH_BSLASH, CH_QUOTE,
                                                             CH_QUOTE)};
              end else begin
                line_text = {line_text, CH_BSLASH};
                case ($urandom_range(5))
                  0: line_text = {line_text, CH_BSLASH};
                  1: line_text = {line_text, CH_QUOTE};
                  2: line_text = {line_text, CH_N};
                  3: line_text = {line_text, CH_R};
                  4: line_text = {line_text, CH_T};
                  default: begin
                    line_text = {line_text, CH_X};
                    line_text = {line_text, 8'(hex_chars[$urandom_range(21)])};
                    line_text = {line_text, 8'(hex_chars[$urandom_range(21)])};
                  end
                endcase
              end
            end
            line_text = {line_text, CH_QUOTE};
          end
        end
        if ($urandom_range(3) == 0) begin
          if ($urandom_range(1)) line_text = {line_text, CH_SPACE};
          line_text = {line_text, CH_HASH};
          repeat ($urandom_range(5)) line_text = {line_text, 8'($urandom_range(255))};
        end
        // broken lines: cut short or one character swapped for a troublesome one
        if (sel < 22 && line_text.size() > 0) begin
          pos = $urandom_range(line_text.size() - 1);
          if ($urandom_range(1)) begin
            while (line_text.size() > pos) void'(line_text.pop_back());
          end else begin
            line_text[pos] = special_char();
          end
        end
      end
      foreach (line_text[i]) queue_item(OP_CHAR, line_text[i]);
      queue_eol();
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_items) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS quoted_escape_tokenizer_top");
    end else begin
      if (expected_results.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      $display("FAIL quoted_escape_tokenizer_top");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/qet_pkg.sv
sv/qet_decode.sv
sv/quoted_escape_tokenizer_top.sv
sv/qet_checker.sv
dv/quoted_escape_tokenizer_top_test.sv
